// ===== src/sync_packet_deframer_fletcher_check_top_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_PACKET_DEFRAMER_FLETCHER_CHECK_TOP_DEFINES_SVH
`define SYNC_PACKET_DEFRAMER_FLETCHER_CHECK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// When the antecedent holds, the consequent must hold in the same cycle.
`define SPDFC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// When the antecedent holds, the consequent must hold in the next cycle.
`define SPDFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define SPDFC_ASSERT_SAME(label, clk, rst, ante, cons)
`define SPDFC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/spdfc_pkg.sv =====
// Constants and codes for the sync packet deframer with Fletcher check.
package spdfc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'h75;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h65;
   localparam logic [BYTE_W-1:0] DESC_RESET = 8'h80;

   // Parser phases.
   localparam logic [PHASE_W-1:0] PH_HUNT_U = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HUNT_E = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DESC = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CHK_HI = 3'd5;
   localparam logic [PHASE_W-1:0] PH_CHK_LO = 3'd6;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Register word index of expected_descriptor.
   localparam logic REG_EXPECTED_DESC = 1'b0;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   data;
      logic [BYTE_W-1:0]   index;
      logic [BYTE_W-1:0]   length;
      logic                check_ok;
      logic                last;
   } result_type;

endpackage

// ===== src/sync_packet_deframer_fletcher_check_top.sv =====
// Sync packet deframer: sync hunt, descriptor match, payload forward, Fletcher check.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_stall  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_kind .. rsp_frame_last
//   csr     | in/out    | APB, pready always 1 | expected_descriptor at address 0
//
// One byte per cycle while the output is not stalled: a byte is held in the input register,
// is parsed by the phase logic and its result (if any) lands in the output register when
// the input register moves on.
// Reset is synchronous and active high; it returns the parser to the sync hunt.
// A stalled output holds the input register; a third byte then sees req_stall.
`include "sync_packet_deframer_fletcher_check_top_defines.svh"

module sync_packet_deframer_fletcher_check_top
   import spdfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_out_kind,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [BYTE_W-1:0]     rsp_out_index,
   output logic [BYTE_W-1:0]     rsp_payload_length,
   output logic                  rsp_checksum_ok,
   output logic                  rsp_frame_last,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [BYTE_W-1:0]  desc_ff;

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  sum1_ff, sum1_in;
   logic [BYTE_W-1:0]  sum2_ff, sum2_in;
   logic [BYTE_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0]  seen_ff, seen_in;
   logic [BYTE_W-1:0]  chk_hi_ff, chk_hi_in;

   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic               advance;
   logic               work;
   logic               produce;
   logic [BYTE_W-1:0]  add1;
   logic [BYTE_W-1:0]  seen_next;
   result_type         result;

   // The input register moves on when the output register is free or being emptied.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign work      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign add1      = sum1_ff + in_byte_ff;
   assign seen_next = seen_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      sum1_in   = sum1_ff;
      sum2_in   = sum2_ff;
      len_in    = len_ff;
      seen_in   = seen_ff;
      chk_hi_in = chk_hi_ff;
      produce   = 1'b0;
      result    = '0;
      result.length = len_ff;
      unique case (phase_ff)
         PH_HUNT_E: begin
            if (in_byte_ff == SYNC_SECOND) begin
               sum1_in  = add1;
               sum2_in  = sum2_ff + add1;
               phase_in = PH_DESC;
            end else begin
               phase_in = PH_HUNT_U;
            end
         end
         PH_DESC: begin
            if (in_byte_ff == desc_ff) begin
               sum1_in  = add1;
               sum2_in  = sum2_ff + add1;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HUNT_U;
            end
         end
         PH_LEN: begin
            sum1_in  = add1;
            sum2_in  = sum2_ff + add1;
            len_in   = in_byte_ff;
            seen_in  = '0;
            phase_in = (in_byte_ff == '0) ? PH_CHK_HI : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum1_in      = add1;
            sum2_in      = sum2_ff + add1;
            produce      = 1'b1;
            result.kind  = KIND_PAYLOAD;
            result.data  = in_byte_ff;
            result.index = seen_ff;
            seen_in      = seen_next;
            if (seen_next == len_ff) begin
               phase_in = PH_CHK_HI;
            end
         end
         PH_CHK_HI: begin
            chk_hi_in = in_byte_ff;
            phase_in  = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            produce         = 1'b1;
            result.kind     = KIND_FRAME_END;
            result.check_ok = (chk_hi_ff == sum1_ff) && (in_byte_ff == sum2_ff);
            result.last     = 1'b1;
            phase_in        = PH_HUNT_U;
         end
         default: begin
            // Hunting for the first sync byte; unused codes land here too.
            if (in_byte_ff == SYNC_FIRST) begin
               sum1_in  = SYNC_FIRST;
               sum2_in  = SYNC_FIRST;
               phase_in = PH_HUNT_E;
            end else begin
               phase_in = PH_HUNT_U;
            end
         end
      endcase
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      // An empty input register takes a transfer even while the output is stalled.
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = work && produce;
         if (work && produce) begin
            out_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT_U;
         sum1_ff      <= '0;
         sum2_ff      <= '0;
         len_ff       <= '0;
         seen_ff      <= '0;
         chk_hi_ff    <= '0;
         desc_ff      <= DESC_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (work) begin
            phase_ff  <= phase_in;
            sum1_ff   <= sum1_in;
            sum2_ff   <= sum2_in;
            len_ff    <= len_in;
            seen_ff   <= seen_in;
            chk_hi_ff <= chk_hi_in;
         end
         if (psel && penable && pwrite && (paddr[2] == REG_EXPECTED_DESC)) begin
            desc_ff <= pwdata[BYTE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      out_ff <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_kind       = out_ff.kind;
   assign rsp_out_byte       = out_ff.data;
   assign rsp_out_index      = out_ff.index;
   assign rsp_payload_length = out_ff.length;
   assign rsp_checksum_ok    = out_ff.check_ok;
   assign rsp_frame_last     = out_ff.last;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_EXPECTED_DESC)
                   ? {{(CSR_DATA_W-BYTE_W){1'b0}}, desc_ff} : '0;

   `SPDFC_ASSERT_SAME(a_end_fields, clock, reset, out_valid_ff && out_ff.last,
      (out_ff.kind == KIND_FRAME_END) && (out_ff.data == '0) && (out_ff.index == '0))
   `SPDFC_ASSERT_SAME(a_index_in_range, clock, reset,
      out_valid_ff && (out_ff.kind == KIND_PAYLOAD), out_ff.index < out_ff.length)
   `SPDFC_ASSERT_SAME(a_seen_below_len, clock, reset, phase_ff == PH_PAYLOAD,
      seen_ff < len_ff)
   `SPDFC_ASSERT_NEXT(a_held_byte_kept, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff))

endmodule
